// File: hw/rtl/hsv_pkg.sv
package hsv_pkg;

  // accumulator geometry
  localparam int ROWS         = 1024;
  localparam int COLS         = 180;
  localparam int ACC_WIDTH    = 24;
  localparam int ROW_W        = $clog2(ROWS);
  localparam int DEPTH        = ROWS * COLS;
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int CORDIC_STEPS = 15;
  localparam int ANGLE_BINS   = 180;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  typedef enum logic {
    OP_VOTE = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_MUL,
    BK_SUM,
    BK_ROOT,
    BK_DIV,
    BK_RHO,
    BK_BIN,
    BK_ADDR,
    BK_READ,
    BK_MODIFY,
    BK_OUT
  } back_state_e;

  // classified item handed from front to back
  typedef struct packed {
    op_e                op;
    logic signed [14:0] xc;
    logic signed [14:0] yc;
    logic signed [14:0] u;
    logic signed [14:0] v;
    logic [7:0]         theta;
    logic [9:0]         rho;
    logic               read_ok;
  } task_t;

  // frame geometry seen by front and back
  typedef struct packed {
    logic [12:0] cx;
    logic [12:0] cy;
    logic [15:0] hd;
    logic        busy;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  theta_bin;
    logic [9:0]  rho_bin;
    logic [23:0] cell_value;
    logic        dropped;
  } res_t;

  // arctangent of 2^-i in 1/65536 turn
  function automatic logic [13:0] atan_turn(input logic [3:0] i);
    logic [13:0] a;
    unique case (i)
      4'd0:    a = 14'd8192;
      4'd1:    a = 14'd4836;
      4'd2:    a = 14'd2555;
      4'd3:    a = 14'd1297;
      4'd4:    a = 14'd651;
      4'd5:    a = 14'd326;
      4'd6:    a = 14'd163;
      4'd7:    a = 14'd81;
      4'd8:    a = 14'd41;
      4'd9:    a = 14'd20;
      4'd10:   a = 14'd10;
      4'd11:   a = 14'd5;
      4'd12:   a = 14'd3;
      4'd13:   a = 14'd1;
      4'd14:   a = 14'd1;
      default: a = 14'd0;
    endcase
    return a;
  endfunction

  // cell to the 24-bit result field
  function automatic logic [23:0] cell_field(input logic [ACC_WIDTH-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[23:0];
  endfunction

endpackage

// File: hw/rtl/hsv_if.sv
interface hsv_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [13:0] x_start;
  logic [13:0] y_start;
  logic [13:0] x_end;
  logic [13:0] y_end;
  logic [7:0]  read_theta;
  logic [9:0]  read_rho;
  modport source (output valid, operation, x_start, y_start, x_end, y_end, read_theta,
                  read_rho, input ready);
  modport sink (input valid, operation, x_start, y_start, x_end, y_end, read_theta,
                read_rho, output ready);
endinterface

interface hsv_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  theta_bin;
  logic [9:0]  rho_bin;
  logic [23:0] cell_value;
  logic        dropped;
  modport source (output valid, theta_bin, rho_bin, cell_value, dropped, input ready);
  modport sink (input valid, theta_bin, rho_bin, cell_value, dropped, output ready);
endinterface

interface hsv_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hsv_pkg::CFG_IDX_W-1:0]  index;
  logic [9:0]                     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/hough_segment_voting.sv
// Hough line accumulator fed with segments. A vote item (operation 0) carries two endpoints
// in 1/16 pixel; the block centres the first endpoint on the frame, finds the normal angle by
// CORDIC and bins it to whole degrees (0..179), works out rho of the first endpoint and
// adds the segment length (q.4, saturating) to the cell at that angle and at row
// (rho + half diagonal) / 16; a vote whose row falls outside the accumulator is reported
// with dropped set and changes nothing. A read item (operation 1) returns one cell and
// clears it. Every item gives exactly one result. Items run one at a time in the back end:
// a vote waits on the square root for the length and on the restoring divider for rho,
// and a vote with equal y skips the divider. A result waiting on the output holds the
// back end; a two-entry queue lets the input side take up to two further items meanwhile.
// After reset the block clears all 184320 cells of the accumulator memory, one cell a
// cycle, and takes no item until that is done. Writing frame_width or frame_height
// recomputes the half diagonal, and no item is taken until that is done.
module hough_segment_voting (
  input  logic      clk_i,
  input  logic      rst_ni,
  hsv_in_if.sink    in_ch,
  hsv_out_if.source out_ch,
  hsv_cfg_if.sink   cfg_ch
);
  import hsv_pkg::*;

  cfg_t  cfg;
  task_t push_task;
  task_t head_task;
  logic  push;
  logic  pop;
  logic  full;
  logic  empty;
  logic  clearing;

  // frame geometry
  hsv_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg_ch),
    .cfg_o  (cfg)
  );

  // accept and classify
  hsv_front u_front (
    .in_ch      (in_ch),
    .cfg_i      (cfg),
    .clearing_i (clearing),
    .full_i     (full),
    .push_o     (push),
    .task_o     (push_task)
  );

  // decoupling queue
  hsv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_task),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .data_o  (head_task)
  );

  // arithmetic and accumulator update
  hsv_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .task_i     (head_task),
    .pop_o      (pop),
    .cfg_i      (cfg),
    .clearing_o (clearing),
    .out_ch     (out_ch)
  );

endmodule

// File: hw/rtl/hsv_ram.sv
module hsv_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/hsv_isqrt.sv
module hsv_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] operand_i,
  output logic        done_o,
  output logic [15:0] root_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [31:0] bit_q, bit_d;
  logic [31:0] trial;

  assign trial = root_q + bit_q;

  // one result bit per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    root_d = root_q;
    bit_d  = bit_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'd16;
      rem_d  = operand_i;
      root_d = '0;
      bit_d  = 32'h4000_0000;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_d  = rem_q - trial;
        root_d = (root_q >> 1) + bit_q;
      end else begin
        root_d = root_q >> 1;
      end
      bit_d = bit_q >> 2;
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    bit_q  <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = root_q[15:0];

endmodule

// File: hw/rtl/hsv_cfg.sv
module hsv_cfg (
  input  logic            clk_i,
  input  logic            rst_ni,
  hsv_cfg_if.sink         cfg,
  output hsv_pkg::cfg_t   cfg_o
);
  import hsv_pkg::*;

  logic [9:0]  width_q, width_d;
  logic [9:0]  height_q, height_d;
  logic [15:0] hd_q, hd_d;
  logic        start_q, start_d;
  logic        busy_q, busy_d;
  logic        root_done;
  logic [15:0] root;
  logic [18:0] sq_sum;
  logic [31:0] operand;

  assign cfg.ready = 1'b1;

  // register writes
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    start_d  = 1'b0;
    if (cfg.valid && cfg.index == CFG_FRAME_WIDTH) begin
      width_d = cfg.data;
      start_d = 1'b1;
    end
    if (cfg.valid && cfg.index == CFG_FRAME_HEIGHT) begin
      height_d = cfg.data;
      start_d  = 1'b1;
    end
  end

  // half diagonal in q.4: sqrt(256 * (a^2 + b^2))
  assign sq_sum  = 19'(18'(width_q[9:1]) * 18'(width_q[9:1]))
                 + 19'(18'(height_q[9:1]) * 18'(height_q[9:1]));
  assign operand = {5'b0, sq_sum, 8'b0};

  hsv_isqrt u_isqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_q),
    .operand_i (operand),
    .done_o    (root_done),
    .root_o    (root)
  );

  always_comb begin
    hd_d   = root_done ? root : hd_q;
    busy_d = start_d ? 1'b1 : (root_done ? 1'b0 : busy_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 10'd640;
      height_q <= 10'd480;
      hd_q     <= 16'd6400;
      start_q  <= 1'b0;
      busy_q   <= 1'b0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      hd_q     <= hd_d;
      start_q  <= start_d;
      busy_q   <= busy_d;
    end
  end

  assign cfg_o.cx   = {width_q[9:1], 4'b0};
  assign cfg_o.cy   = {height_q[9:1], 4'b0};
  assign cfg_o.hd   = hd_q;
  assign cfg_o.busy = busy_q | start_q;

endmodule

// File: hw/rtl/hsv_front.sv
module hsv_front (
  hsv_in_if.sink          in_ch,
  input  hsv_pkg::cfg_t   cfg_i,
  input  logic            clearing_i,
  input  logic            full_i,
  output logic            push_o,
  output hsv_pkg::task_t  task_o
);
  import hsv_pkg::*;

  logic signed [14:0] dx;
  logic signed [14:0] u0;
  logic               flip;

  // take an item only when the queue has room, the geometry is settled and the clear is done
  assign in_ch.ready = !full_i && !cfg_i.busy && !clearing_i;
  assign push_o      = in_ch.valid && in_ch.ready;

  // segment normal, turned into the upper half plane
  assign dx   = $signed({1'b0, in_ch.x_end}) - $signed({1'b0, in_ch.x_start});
  assign u0   = $signed({1'b0, in_ch.y_start}) - $signed({1'b0, in_ch.y_end});
  assign flip = dx < 0 || (dx == 0 && u0 < 0);

  always_comb begin
    task_o.op      = op_e'(in_ch.operation);
    task_o.xc      = $signed({1'b0, in_ch.x_start}) - $signed({2'b00, cfg_i.cx});
    task_o.yc      = $signed({1'b0, in_ch.y_start}) - $signed({2'b00, cfg_i.cy});
    task_o.u       = flip ? -u0 : u0;
    task_o.v       = flip ? -dx : dx;
    task_o.theta   = in_ch.read_theta;
    task_o.rho     = in_ch.read_rho;
    // read address inside the accumulator
    task_o.read_ok = (32'(in_ch.read_theta) < 32'(COLS))
                  && (32'(in_ch.read_rho) < 32'(ROWS));
  end

endmodule

// File: hw/rtl/hsv_queue.sv
module hsv_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hsv_pkg::task_t  data_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output hsv_pkg::task_t  data_o
);
  import hsv_pkg::*;

  task_t      entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = entry_q[rd_ptr_q];

  // pointers and fill level
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: hw/rtl/hsv_back.sv
module hsv_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  hsv_pkg::task_t  task_i,
  output logic            pop_o,
  input  hsv_pkg::cfg_t   cfg_i,
  output logic            clearing_o,
  hsv_out_if.source       out_ch
);
  import hsv_pkg::*;

  back_state_e          state_q, state_d;
  task_t                tk_q, tk_d;
  logic [27:0]          uu_q, uu_d, vv_q, vv_d;
  logic signed [29:0]   xu_q, xu_d, yv_q, yv_d;
  logic signed [31:0]   num_q, num_d;
  logic [15:0]          len_q, len_d;
  logic signed [25:0]   cx_q, cx_d, cy_q, cy_d;
  logic signed [17:0]   cz_q, cz_d;
  logic [3:0]           step_q, step_d;
  logic [30:0]          dvd_q, dvd_d;
  logic [16:0]          rem_q, rem_d;
  logic [30:0]          quo_q, quo_d;
  logic [4:0]           dcnt_q, dcnt_d;
  logic                 neg_q, neg_d;
  logic signed [31:0]   rho_q, rho_d;
  logic [7:0]           bin_q, bin_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [ADDR_W-1:0]    addr_q, addr_d;
  logic [ADDR_W-1:0]    clr_q, clr_d;
  res_t                 res_q, res_d;
  res_t                 out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  logic                 root_done;
  logic [15:0]          root;
  logic                 ram_we, ram_re;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [ACC_WIDTH-1:0] ram_wdata, ram_rdata;
  logic                 out_free;
  logic signed [14:0]   nu;
  logic signed [25:0]   sh_x, sh_y;
  logic [16:0]          rem_sh;
  logic [14:0]          ang;
  logic [22:0]          ang_prod;
  logic [7:0]           bin_c;
  logic signed [32:0]   sum, sum_row;
  logic                 drop_c;
  logic [ACC_WIDTH:0]   cell_sum;
  logic [ACC_WIDTH-1:0] cell_new;

  assign out_free   = !out_valid_q || out_ch.ready;
  assign clearing_o = state_q == BK_CLEAR;

  // length of the normal
  hsv_isqrt u_isqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (state_q == BK_SUM),
    .operand_i (32'(uu_q) + 32'(vv_q)),
    .done_o    (root_done),
    .root_o    (root)
  );

  // accumulator memory
  hsv_ram #(
    .WIDTH (ACC_WIDTH),
    .DEPTH (DEPTH)
  ) u_acc (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_CLEAR: begin
        if (32'(clr_q) == DEPTH - 1) state_d = BK_IDLE;
      end
      BK_IDLE: begin
        if (!empty_i) begin
          if (task_i.op == OP_VOTE) state_d = BK_MUL;
          else if (task_i.read_ok)  state_d = BK_ADDR;
          else                      state_d = BK_OUT;
        end
      end
      BK_MUL:  state_d = BK_SUM;
      BK_SUM:  state_d = BK_ROOT;
      BK_ROOT: begin
        if (root_done) state_d = (tk_q.u == 0) ? BK_BIN : BK_DIV;
      end
      BK_DIV: begin
        if (dcnt_q == 5'd1) state_d = BK_RHO;
      end
      BK_RHO:    state_d = BK_BIN;
      BK_BIN:    state_d = drop_c ? BK_OUT : BK_ADDR;
      BK_ADDR:   state_d = BK_READ;
      BK_READ:   state_d = BK_MODIFY;
      BK_MODIFY: state_d = BK_OUT;
      BK_OUT: begin
        if (out_free) state_d = BK_IDLE;
      end
      default:   state_d = BK_IDLE;
    endcase
  end

  // cordic micro-rotation, floor shifts
  assign sh_x = cx_q >>> step_q;
  assign sh_y = cy_q >>> step_q;
  assign nu   = -tk_q.u;

  // restoring divider, one quotient bit per cycle
  assign rem_sh = {rem_q[15:0], dvd_q[30]};

  // angle to whole-degree bin
  always_comb begin
    if (tk_q.u == 0)      ang = 15'd16384;
    else if (tk_q.v == 0) ang = 15'd0;
    else if (cz_q < 0)    ang = 15'd0;
    else if (cz_q > 18'sd32767) ang = 15'd32767;
    else                  ang = cz_q[14:0];
  end
  assign ang_prod = 23'(ang) * 23'(ANGLE_BINS);
  assign bin_c    = ang_prod[22:15];

  // row from rho plus half diagonal
  assign sum     = 33'(rho_q) + $signed({17'b0, cfg_i.hd});
  assign sum_row = sum >>> 4;
  assign drop_c  = sum < 0 || sum_row >= $signed(33'(ROWS));

  // saturating add of the length
  assign cell_sum = {1'b0, ram_rdata} + (ACC_WIDTH + 1)'(len_q);
  assign cell_new = cell_sum[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : cell_sum[ACC_WIDTH-1:0];

  // datapath and outputs
  always_comb begin
    tk_d        = tk_q;
    uu_d        = uu_q;
    vv_d        = vv_q;
    xu_d        = xu_q;
    yv_d        = yv_q;
    num_d       = num_q;
    len_d       = len_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    cz_d        = cz_q;
    step_d      = step_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dcnt_d      = dcnt_q;
    neg_d       = neg_q;
    rho_d       = rho_q;
    bin_d       = bin_q;
    row_d       = row_q;
    addr_d      = addr_q;
    clr_d       = clr_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ch.ready;
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = addr_q;
    ram_wdata   = '0;

    // cordic runs alongside the square root
    if ((state_q == BK_SUM || state_q == BK_ROOT) && 32'(step_q) != CORDIC_STEPS) begin
      if (!cy_q[25]) begin
        cx_d = cx_q + sh_y;
        cy_d = cy_q - sh_x;
        cz_d = cz_q + $signed({4'b0, atan_turn(step_q)});
      end else begin
        cx_d = cx_q - sh_y;
        cy_d = cy_q + sh_x;
        cz_d = cz_q - $signed({4'b0, atan_turn(step_q)});
      end
      step_d = step_q + 4'd1;
    end

    unique case (state_q)
      BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + ADDR_W'(1);
      end
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          tk_d  = task_i;
          bin_d = task_i.theta;
          row_d = ROW_W'(32'(task_i.rho));
          res_d = '{theta_bin: task_i.theta, rho_bin: task_i.rho,
                    cell_value: 24'd0, dropped: 1'b0};
        end
      end
      BK_MUL: begin
        uu_d = 28'(tk_q.u * tk_q.u);
        vv_d = 28'(tk_q.v * tk_q.v);
        xu_d = 30'(tk_q.xc) * 30'(tk_q.u);
        yv_d = 30'(tk_q.yc) * 30'(tk_q.v);
        step_d = '0;
        if (tk_q.u < 0) begin
          cx_d = {{3{tk_q.v[14]}}, tk_q.v, 8'b0};
          cy_d = {{3{nu[14]}}, nu, 8'b0};
          cz_d = 18'sd16384;
        end else begin
          cx_d = {{3{tk_q.u[14]}}, tk_q.u, 8'b0};
          cy_d = {{3{tk_q.v[14]}}, tk_q.v, 8'b0};
          cz_d = 18'sd0;
        end
      end
      BK_SUM: begin
        num_d = 32'(xu_q) + 32'(yv_q);
      end
      BK_ROOT: begin
        if (root_done) begin
          len_d  = root;
          rho_d  = 32'(tk_q.yc);
          neg_d  = num_q < 0;
          dvd_d  = (num_q < 0) ? 31'(-num_q) : 31'(num_q);
          rem_d  = '0;
          quo_d  = '0;
          dcnt_d = 5'd31;
        end
      end
      BK_DIV: begin
        if (rem_sh >= {1'b0, len_q}) begin
          rem_d = rem_sh - {1'b0, len_q};
          quo_d = {quo_q[29:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[29:0], 1'b0};
        end
        dvd_d  = {dvd_q[29:0], 1'b0};
        dcnt_d = dcnt_q - 5'd1;
      end
      BK_RHO: begin
        // floor for negative quotients
        if (neg_q) rho_d = -$signed({1'b0, quo_q}) - $signed(32'(rem_q != '0));
        else       rho_d = $signed({1'b0, quo_q});
      end
      BK_BIN: begin
        bin_d = bin_c;
        row_d = ROW_W'(sum_row);
        res_d = '{theta_bin: bin_c, rho_bin: 10'd0, cell_value: 24'd0, dropped: 1'b1};
      end
      BK_ADDR: begin
        addr_d = ADDR_W'(int'(bin_q) * ROWS + int'(row_q));
      end
      BK_READ: begin
        ram_re = 1'b1;
      end
      BK_MODIFY: begin
        ram_we = 1'b1;
        if (tk_q.op == OP_READ) begin
          ram_wdata = '0;
          res_d     = '{theta_bin: tk_q.theta, rho_bin: tk_q.rho,
                        cell_value: cell_field(ram_rdata), dropped: 1'b0};
        end else begin
          ram_wdata = cell_new;
          res_d     = '{theta_bin: bin_q, rho_bin: 10'(32'(row_q)),
                        cell_value: cell_field(cell_new), dropped: 1'b0};
        end
      end
      BK_OUT: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      dcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      dcnt_q      <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tk_q   <= tk_d;
    uu_q   <= uu_d;
    vv_q   <= vv_d;
    xu_q   <= xu_d;
    yv_q   <= yv_d;
    num_q  <= num_d;
    len_q  <= len_d;
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    cz_q   <= cz_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    neg_q  <= neg_d;
    rho_q  <= rho_d;
    bin_q  <= bin_d;
    row_q  <= row_d;
    addr_q <= addr_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.theta_bin  = out_q.theta_bin;
  assign out_ch.rho_bin    = out_q.rho_bin;
  assign out_ch.cell_value = out_q.cell_value;
  assign out_ch.dropped    = out_q.dropped;

endmodule
